### src/pcr_pkg.sv
// shared types, constants and helpers of the palette channel remap block
// no dependencies; every other file refers to this package by scoped names
package pcr_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int VAL_W         = 8;
  localparam int CHANNELS      = 3;
  localparam int OUT_DEPTH     = 4;
  localparam int OUT_PTR_W     = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W     = $clog2(OUT_DEPTH + 1);

  // channel slots in packed vectors
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  typedef enum logic [1:0] {
    CMD_WR_PALETTE = 2'd0,
    CMD_WR_MAP     = 2'd1,
    CMD_REBUILD    = 2'd2,
    CMD_REMAP      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FETCH,
    B_SCAN,
    B_WRITE,
    B_DONE
  } bld_state_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ADDR_W-1:0] entry_index;
    logic [VAL_W-1:0] red_value;
    logic [VAL_W-1:0] green_value;
    logic [VAL_W-1:0] blue_value;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] red_index;
    logic [ADDR_W-1:0] green_index;
    logic [ADDR_W-1:0] blue_index;
    logic              build_done;
  } out_item_t;

  typedef logic [CHANNELS-1:0][VAL_W-1:0]  chan_vec_t;
  typedef logic [CHANNELS-1:0][ADDR_W-1:0] idx_vec_t;

  // palette / input map write request
  typedef struct packed {
    logic              pal_en;
    logic              map_en;
    logic [ADDR_W-1:0] addr;
    chan_vec_t         rgb;
  } tbl_wr_t;

  // remap table write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    idx_vec_t          idx;
  } remap_wr_t;

  typedef struct packed {
    logic idle;
    logic done_req;
  } bld_status_t;

  function automatic logic [VAL_W-1:0] absdiff(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### src/pcr_build.sv
// palette and input map memories plus the rebuild sequencer
// scans the palette once per input map entry, all three channels in parallel
// depends on pcr_pkg
module pcr_build (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  identity_input_map,
  input  pcr_pkg::tbl_wr_t      tbl_wr,
  input  logic                  start,
  input  logic                  done_ack,
  output pcr_pkg::bld_status_t  status,
  output pcr_pkg::remap_wr_t    remap_wr
);

  localparam int AW = pcr_pkg::ADDR_W;
  localparam int VW = pcr_pkg::VAL_W;
  localparam int NC = pcr_pkg::CHANNELS;

  pcr_pkg::chan_vec_t pal_mem [pcr_pkg::TABLE_ENTRIES];
  pcr_pkg::chan_vec_t map_mem [pcr_pkg::TABLE_ENTRIES];

  pcr_pkg::bld_state_t state, state_next;
  logic [AW-1:0]   i;
  logic [AW:0]     k;
  logic [AW:0]     k_m1;
  pcr_pkg::chan_vec_t pal_q, map_q, want, err;
  pcr_pkg::idx_vec_t  best_idx;
  pcr_pkg::chan_vec_t best_err;
  logic [NC-1:0]   take;
  logic            pal_rd_en, map_rd_en;
  logic [AW-1:0]   pal_rd_addr;
  logic            scan_last, i_last;

  assign scan_last = (k == (AW+1)'(pcr_pkg::TABLE_ENTRIES));
  assign i_last    = (i == AW'(pcr_pkg::TABLE_ENTRIES - 1));
  assign k_m1      = k - 1'b1;

  // memories: written from the request channel, read by the sequencer
  always_ff @(posedge clk) begin
    if (tbl_wr.pal_en) begin
      pal_mem[tbl_wr.addr] <= tbl_wr.rgb;
    end
    if (tbl_wr.map_en) begin
      map_mem[tbl_wr.addr] <= tbl_wr.rgb;
    end
    if (pal_rd_en) begin
      pal_q <= pal_mem[pal_rd_addr];
    end
    if (map_rd_en) begin
      map_q <= map_mem[i];
    end
  end

  // per channel distance of the palette entry just read
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      want[c] = identity_input_map ? VW'(i) : map_q[c];
      err[c]  = pcr_pkg::absdiff(pal_q[c], want[c]);
      take[c] = (k == (AW+1)'(1)) || (err[c] < best_err[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == pcr_pkg::B_SCAN) begin
      for (int c = 0; c < NC; c++) begin
        if (take[c]) begin
          best_idx[c] <= k_m1[AW-1:0];
          best_err[c] <= err[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcr_pkg::B_IDLE;
      i     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      case (state)
        pcr_pkg::B_IDLE: begin
          i <= '0;
        end
        pcr_pkg::B_FETCH: begin
          k <= (AW+1)'(1);
        end
        pcr_pkg::B_SCAN: begin
          k <= k + 1'b1;
        end
        pcr_pkg::B_WRITE: begin
          i <= i + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pcr_pkg::B_IDLE:  if (start) state_next = pcr_pkg::B_FETCH;
      pcr_pkg::B_FETCH: state_next = pcr_pkg::B_SCAN;
      pcr_pkg::B_SCAN:  if (scan_last) state_next = pcr_pkg::B_WRITE;
      pcr_pkg::B_WRITE: state_next = i_last ? pcr_pkg::B_DONE : pcr_pkg::B_FETCH;
      pcr_pkg::B_DONE:  if (done_ack) state_next = pcr_pkg::B_IDLE;
      default:          state_next = pcr_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pal_rd_en       = 1'b0;
    pal_rd_addr     = '0;
    map_rd_en       = 1'b0;
    remap_wr.en     = 1'b0;
    remap_wr.addr   = i;
    remap_wr.idx    = best_idx;
    status.idle     = 1'b0;
    status.done_req = 1'b0;
    case (state)
      pcr_pkg::B_IDLE: begin
        status.idle = 1'b1;
      end
      pcr_pkg::B_FETCH: begin
        pal_rd_en = 1'b1;
        map_rd_en = 1'b1;
      end
      pcr_pkg::B_SCAN: begin
        pal_rd_en   = !scan_last;
        pal_rd_addr = k[AW-1:0];
      end
      pcr_pkg::B_WRITE: begin
        remap_wr.en = 1'b1;
      end
      pcr_pkg::B_DONE: begin
        status.done_req = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### src/pcr_remap_tab.sv
// remap table: one memory per channel so a pixel reads three addresses at once
// depends on pcr_pkg
module pcr_remap_tab (
  input  logic               clk,
  input  pcr_pkg::remap_wr_t wr,
  input  logic               rd_en,
  input  pcr_pkg::chan_vec_t rd_addr,
  output pcr_pkg::idx_vec_t  rd_q
);

  localparam int AW = pcr_pkg::ADDR_W;

  logic [AW-1:0] red_mem   [pcr_pkg::TABLE_ENTRIES];
  logic [AW-1:0] green_mem [pcr_pkg::TABLE_ENTRIES];
  logic [AW-1:0] blue_mem  [pcr_pkg::TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      red_mem[wr.addr]   <= wr.idx[pcr_pkg::CH_RED];
      green_mem[wr.addr] <= wr.idx[pcr_pkg::CH_GREEN];
      blue_mem[wr.addr]  <= wr.idx[pcr_pkg::CH_BLUE];
    end
    if (rd_en) begin
      rd_q[pcr_pkg::CH_RED]   <= red_mem[AW'(rd_addr[pcr_pkg::CH_RED])];
      rd_q[pcr_pkg::CH_GREEN] <= green_mem[AW'(rd_addr[pcr_pkg::CH_GREEN])];
      rd_q[pcr_pkg::CH_BLUE]  <= blue_mem[AW'(rd_addr[pcr_pkg::CH_BLUE])];
    end
  end

endmodule

### src/pcr_out_fifo.sv
// small result queue between the block and the downstream receiver
// depends on pcr_pkg
module pcr_out_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  pcr_pkg::out_item_t                push_data,
  input  logic                              pop,
  output logic [pcr_pkg::OUT_CNT_W-1:0]     count,
  output pcr_pkg::out_item_t                head
);

  pcr_pkg::out_item_t            slots [pcr_pkg::OUT_DEPTH];
  logic [pcr_pkg::OUT_PTR_W-1:0] wr_ptr, rd_ptr;

  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/palette_channel_remap_top.sv
// top level of the palette channel remap block
// instantiates pcr_build, pcr_remap_tab and pcr_out_fifo; depends on pcr_pkg
//
// usage:
// - in channel (in_valid / in_stall / in_data) carries one request: write a
//   palette entry, write an input map entry, rebuild the remap table, or
//   remap one rgb pixel
// - out channel (out_valid / out_stall / out_data) returns one result per
//   rebuild (build_done set, indexes zero) and one per pixel; writes give none
// - cfg channel (cfg_valid / cfg_ready / cfg_data) sets identity_input_map;
//   always ready; the user must see that it is written only while the block
//   is idle, which the block itself does not enforce
// - pixel requests stream at one per cycle while in_stall is low; each result
//   is registered by the remap memory read, then by the result queue
// - a rebuild walks 256 map entries, each one map fetch, 256 palette reads on
//   the single read port and one remap write; no request is taken while it runs
// - when the receiver stalls, results pile up in a four-deep queue and the
//   in channel stalls once the queue plus the read in flight hold three results
// - reset clears the sequencer, queue and identity register; table contents
//   stay undefined until written
module palette_channel_remap_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcr_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int CW = pcr_pkg::OUT_CNT_W;

  logic                   identity_input_map;
  logic                   in_acc;
  logic                   pix_pend;     // pixel remap read in flight
  logic [CW-1:0]          fifo_count;
  logic                   fifo_full;
  logic                   push, pop;
  pcr_pkg::out_item_t     push_data;
  pcr_pkg::tbl_wr_t       tbl_wr;
  pcr_pkg::bld_status_t   bld_status;
  pcr_pkg::remap_wr_t     remap_wr;
  pcr_pkg::idx_vec_t      remap_q;
  pcr_pkg::chan_vec_t     pix_addr;
  logic                   start, done_ack, rd_en;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      identity_input_map <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      identity_input_map <= cfg_data;
    end
  end

  // take requests only while the sequencer is idle and queue room remains
  // for everything in flight
  assign in_stall = !(bld_status.idle &&
                      ((fifo_count + CW'(pix_pend)) <= CW'(pcr_pkg::OUT_DEPTH - 2)));
  assign in_acc   = in_valid && !in_stall;

  // table writes
  assign tbl_wr.pal_en = in_acc && (in_data.cmd == pcr_pkg::CMD_WR_PALETTE);
  assign tbl_wr.map_en = in_acc && (in_data.cmd == pcr_pkg::CMD_WR_MAP);
  assign tbl_wr.addr   = in_data.entry_index;
  assign tbl_wr.rgb    = {in_data.red_value, in_data.green_value, in_data.blue_value};

  assign start = in_acc && (in_data.cmd == pcr_pkg::CMD_REBUILD);
  assign rd_en = in_acc && (in_data.cmd == pcr_pkg::CMD_REMAP);
  assign pix_addr = {in_data.red_value, in_data.green_value, in_data.blue_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_pend <= 1'b0;
    end else begin
      pix_pend <= rd_en;
    end
  end

  pcr_build u_build (
    .clk                (clk),
    .rst                (rst),
    .identity_input_map (identity_input_map),
    .tbl_wr             (tbl_wr),
    .start              (start),
    .done_ack           (done_ack),
    .status             (bld_status),
    .remap_wr           (remap_wr)
  );

  pcr_remap_tab u_remap (
    .clk     (clk),
    .wr      (remap_wr),
    .rd_en   (rd_en),
    .rd_addr (pix_addr),
    .rd_q    (remap_q)
  );

  // results: pixel data when a read lands, else the done marker
  // (never both: no pixel is in flight while a rebuild runs)
  assign fifo_full = (fifo_count == CW'(pcr_pkg::OUT_DEPTH));
  assign done_ack  = bld_status.done_req && !fifo_full;
  assign push      = pix_pend || done_ack;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    if (pix_pend) begin
      push_data.red_index   = remap_q[pcr_pkg::CH_RED];
      push_data.green_index = remap_q[pcr_pkg::CH_GREEN];
      push_data.blue_index  = remap_q[pcr_pkg::CH_BLUE];
      push_data.build_done  = 1'b0;
    end else begin
      push_data.red_index   = '0;
      push_data.green_index = '0;
      push_data.blue_index  = '0;
      push_data.build_done  = 1'b1;
    end
  end

  pcr_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .count     (fifo_count),
    .head      (out_data)
  );

  assign out_valid = (fifo_count != '0);

endmodule

### test/palette_channel_remap_top_tb.sv
// testbench for palette_channel_remap_top: directed table, then random mixed requests
// depends on pcr_pkg and the palette_channel_remap_top rtl; checks against a shadow predictor
`timescale 1ns / 100ps

module palette_channel_remap_top_tb;

  // directed row: one request, and a typed expectation where it is obvious
  typedef struct packed {
    pcr_pkg::in_item_t  req;
    logic               typed;
    pcr_pkg::out_item_t want;
  } dir_row_t;

  localparam int                 DIR_ROWS    = 16;
  localparam int                 PHASES      = 4;
  localparam int                 PHASE_REQS  = 500;
  localparam int                 HOLD_AT     = 800;   // accepted requests before the long hold
  localparam int                 HOLD_CYCLES = 400;
  localparam int                 SETTLE      = 8;     // cycles after the last result before cfg writes
  localparam pcr_pkg::out_item_t NO_TYPED    = '0;
  localparam pcr_pkg::out_item_t BUILD_DONE  = {8'd0, 8'd0, 8'd0, 1'b1};

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  pcr_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pcr_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data  = 1'b0;

  // shadow copy of the block state
  pcr_pkg::chan_vec_t shadow_palette [pcr_pkg::TABLE_ENTRIES];
  pcr_pkg::chan_vec_t shadow_in_map  [pcr_pkg::TABLE_ENTRIES];
  pcr_pkg::idx_vec_t  shadow_remap   [pcr_pkg::TABLE_ENTRIES];
  logic               shadow_identity;

  pcr_pkg::out_item_t results_due [$];
  dir_row_t           dir_tab [DIR_ROWS];
  int                 fail_cnt     = 0;
  int                 accepted_cnt = 0;
  int                 burst_left   = 0;
  bit                 hold_done    = 1'b0;

  palette_channel_remap_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs, e.g. a rebuild that never finishes
  initial begin
    #40_000_000;
    $display("FAIL palette_channel_remap_top");
    $finish;
  end

  // per channel nearest palette index for every map entry, lowest index on a tie
  function automatic void shadow_rebuild();
    int want, gap, best, best_gap;
    for (int i = 0; i < pcr_pkg::TABLE_ENTRIES; i++) begin
      for (int ch = 0; ch < pcr_pkg::CHANNELS; ch++) begin
        want = shadow_identity ? i : int'(shadow_in_map[i][ch]);
        best = 0;
        best_gap = int'(shadow_palette[0][ch]) - want;
        if (best_gap < 0) best_gap = -best_gap;
        for (int k = 1; k < pcr_pkg::TABLE_ENTRIES; k++) begin
          gap = int'(shadow_palette[k][ch]) - want;
          if (gap < 0) gap = -gap;
          if (gap < best_gap) begin
            best_gap = gap;
            best = k;
          end
        end
        shadow_remap[i][ch] = 8'(best);
      end
    end
  endfunction

  // apply one accepted request to the shadow state; returns 1 when a result is due
  function automatic bit shadow_apply(input pcr_pkg::in_item_t req,
                                      output pcr_pkg::out_item_t res);
    pcr_pkg::chan_vec_t rgb;
    rgb[pcr_pkg::CH_RED]   = req.red_value;
    rgb[pcr_pkg::CH_GREEN] = req.green_value;
    rgb[pcr_pkg::CH_BLUE]  = req.blue_value;
    res = '0;
    case (req.cmd)
      pcr_pkg::CMD_WR_PALETTE: begin
        shadow_palette[req.entry_index] = rgb;
        return 1'b0;
      end
      pcr_pkg::CMD_WR_MAP: begin
        shadow_in_map[req.entry_index] = rgb;
        return 1'b0;
      end
      pcr_pkg::CMD_REBUILD: begin
        shadow_rebuild();
        res.build_done = 1'b1;
        return 1'b1;
      end
      default: begin
        res.red_index   = shadow_remap[req.red_value][pcr_pkg::CH_RED];
        res.green_index = shadow_remap[req.green_value][pcr_pkg::CH_GREEN];
        res.blue_index  = shadow_remap[req.blue_value][pcr_pkg::CH_BLUE];
        return 1'b1;
      end
    endcase
  endfunction

  task automatic log_failure(input string what, input pcr_pkg::out_item_t want,
                             input pcr_pkg::out_item_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%0t %s: expected r=%0d g=%0d b=%0d done=%0b, got r=%0d g=%0d b=%0d done=%0b",
               $time, what, want.red_index, want.green_index, want.blue_index,
               want.build_done, got.red_index, got.green_index, got.blue_index,
               got.build_done);
  endtask

  // offer one request, wait for acceptance, then record what it should produce
  // the sender keeps valid high through a burst and drops it for a random gap after
  task automatic send_request(input pcr_pkg::in_item_t req, input logic typed,
                              input pcr_pkg::out_item_t typed_res);
    pcr_pkg::out_item_t res;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    accepted_cnt++;
    if (shadow_apply(req, res))
      results_due.push_back(typed ? typed_res : res);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // mostly short bursts, now and then a long unbroken one
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  // identity register write, only once the block has drained
  task automatic write_identity(input logic value);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    // a trailing table write gives no result, so give it time to land
    repeat (SETTLE) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_identity = value;
  endtask

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    pcr_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        log_failure("unexpected result", NO_TYPED, out_data);
      end else begin
        want = results_due.pop_front();
        if (want.red_index !== out_data.red_index ||
            want.green_index !== out_data.green_index ||
            want.blue_index !== out_data.blue_index ||
            want.build_done !== out_data.build_done)
          log_failure("result mismatch", want, out_data);
      end
    end
  end

  // receiver: stall rate changes every so often, plus one long hold
  // the long hold lets the result queue fill so the input side must stall
  initial begin : receiver
    int stall_pct, span;
    stall_pct = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && accepted_cnt >= HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        if (span == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          span = $urandom_range(20, 80);
        end
        span--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    pcr_pkg::in_item_t req;
    int pick, builds;

    // directed rows, identity on and the ramp palette loaded beforehand:
    // palette red = k, green = 255 - k, blue = k with bit 0 cleared (pairs tie)
    // so a remap of (r, g, b) gives (r, 255 - g, b & 8'hfe)
    dir_tab = '{
      // rebuild: done result, indexes zero
      {pcr_pkg::CMD_REBUILD,    8'd0,   8'd0,   8'd0,   8'd0,   1'b1, BUILD_DONE},
      // channel extremes
      {pcr_pkg::CMD_REMAP,      8'd0,   8'd0,   8'd0,   8'd0,   1'b1,
       {8'd0,   8'd255, 8'd0,   1'b0}},
      {pcr_pkg::CMD_REMAP,      8'd0,   8'd255, 8'd255, 8'd255, 1'b1,
       {8'd255, 8'd0,   8'd254, 1'b0}},
      // odd blue sits between two equal pairs: lower index wins
      {pcr_pkg::CMD_REMAP,      8'd0,   8'd1,   8'd254, 8'd1,   1'b1,
       {8'd1,   8'd1,   8'd0,   1'b0}},
      {pcr_pkg::CMD_REMAP,      8'd0,   8'd128, 8'd127, 8'd129, 1'b1,
       {8'd128, 8'd128, 8'd128, 1'b0}},
      {pcr_pkg::CMD_REMAP,      8'd0,   8'd170, 8'd85,  8'd85,  1'b1,
       {8'd170, 8'd170, 8'd84,  1'b0}},
      // map writes give nothing back, and are ignored while identity is on
      {pcr_pkg::CMD_WR_MAP,     8'd0,   8'd255, 8'd255, 8'd255, 1'b0, NO_TYPED},
      {pcr_pkg::CMD_WR_MAP,     8'd255, 8'd0,   8'd0,   8'd0,   1'b0, NO_TYPED},
      // palette change must not show until the next rebuild
      {pcr_pkg::CMD_WR_PALETTE, 8'd0,   8'd255, 8'd0,   8'd255, 1'b0, NO_TYPED},
      {pcr_pkg::CMD_REMAP,      8'd0,   8'd0,   8'd0,   8'd0,   1'b1,
       {8'd0,   8'd255, 8'd0,   1'b0}},
      {pcr_pkg::CMD_REMAP,      8'd0,   8'd255, 8'd255, 8'd255, 1'b1,
       {8'd255, 8'd0,   8'd254, 1'b0}},
      {pcr_pkg::CMD_REBUILD,    8'd0,   8'd0,   8'd0,   8'd0,   1'b1, BUILD_DONE},
      // after the rebuild the changed entry 0 moves the answers
      {pcr_pkg::CMD_REMAP,      8'd0,   8'd0,   8'd0,   8'd0,   1'b0, NO_TYPED},
      {pcr_pkg::CMD_REMAP,      8'd0,   8'd255, 8'd255, 8'd255, 1'b0, NO_TYPED},
      {pcr_pkg::CMD_REMAP,      8'd0,   8'd15,  8'd240, 8'd128, 1'b0, NO_TYPED},
      {pcr_pkg::CMD_WR_PALETTE, 8'd255, 8'd0,   8'd255, 8'd0,   1'b0, NO_TYPED}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_identity(1'b1);

    // whole palette written before any rebuild reads it
    for (int n = 0; n < pcr_pkg::TABLE_ENTRIES; n++)
      send_request({pcr_pkg::CMD_WR_PALETTE, 8'(n), 8'(n), 8'(255 - n), 8'(n & 8'hfe)},
                   1'b0, NO_TYPED);

    for (int n = 0; n < DIR_ROWS; n++)
      send_request(dir_tab[n].req, dir_tab[n].typed, dir_tab[n].want);

    // whole input map written before the first rebuild with identity off
    for (int n = 0; n < pcr_pkg::TABLE_ENTRIES; n++)
      send_request({pcr_pkg::CMD_WR_MAP, 8'(n), 8'($urandom), 8'($urandom), 8'($urandom)},
                   1'b0, NO_TYPED);

    // random phases, identity alternating; each opens with a rebuild so the new
    // setting takes effect, and at most one more rebuild lands at random
    for (int ph = 0; ph < PHASES; ph++) begin
      write_identity(ph % 2 == 1);
      send_request({pcr_pkg::CMD_REBUILD, 32'd0}, 1'b0, NO_TYPED);
      builds = 1;
      for (int n = 1; n < PHASE_REQS; n++) begin
        req = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 2'b00};
        pick = $urandom_range(0, 99);
        if (builds < 2 && $urandom_range(0, 249) == 0) begin
          req.cmd = pcr_pkg::CMD_REBUILD;
          builds++;
        end else if (pick < 70) begin
          req.cmd = pcr_pkg::CMD_REMAP;
        end else if (pick < 85) begin
          req.cmd = pcr_pkg::CMD_WR_PALETTE;
        end else begin
          req.cmd = pcr_pkg::CMD_WR_MAP;
        end
        send_request(req, 1'b0, NO_TYPED);
      end
    end

    // drain, then leave room for anything stray
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (fail_cnt == 0 && results_due.size() == 0)
      $display("PASS palette_channel_remap_top");
    else
      $display("FAIL palette_channel_remap_top");
    $finish;
  end

endmodule

### sim.f
src/pcr_pkg.sv
src/pcr_build.sv
src/pcr_remap_tab.sv
src/pcr_out_fifo.sv
src/palette_channel_remap_top.sv
test/palette_channel_remap_top_tb.sv
